### design/ked_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ked_pkg: shared types and constants for the keypad event auto-repeat block
// Payload words, controller command/status groups, key code table and the
// configuration register map.
// ----------------------------------------------------------------------------
package ked_pkg;

    // Width of every mask in a result word
    localparam int OUT_W = 18;
    // Entries in the raw key code table
    localparam int MAP_N = 18;
    localparam int BTN_W = 5;

    // Configuration register map
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_IDX    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_IDX = 1'b1;
    localparam logic [15:0] DELAY_RST    = 16'd300;
    localparam logic [15:0] INTERVAL_RST = 16'd100;

    // Item kinds and raw event type
    localparam logic CMD_POLL  = 1'b0;
    localparam logic CMD_EVENT = 1'b1;
    localparam logic [15:0] EVT_KEY = 16'd1;

    // Raw code of each button: up, down, left, right, A, B, X, Y, start,
    // select, menu, L1, L2, R1, R2, plus, minus, power
    localparam logic [15:0] KEY_CODES [MAP_N] = '{
        16'd103, 16'd108, 16'd105, 16'd106, 16'd57, 16'd29, 16'd42, 16'd56,
        16'd28,  16'd97,  16'd1,   16'd18,  16'd15, 16'd20, 16'd14, 16'd115,
        16'd114, 16'd116
    };

    typedef struct packed {
        logic               cmd;
        logic [31:0]        now_ms;
        logic [15:0]        event_type;
        logic [15:0]        key_code;
        logic signed [31:0] key_value;
    } t_in_word;

    typedef struct packed {
        logic [OUT_W-1:0] held_mask;
        logic [OUT_W-1:0] pressed_now_mask;
        logic [OUT_W-1:0] released_now_mask;
        logic [OUT_W-1:0] repeated_now_mask;
    } t_out_word;

    typedef struct packed {
        logic hit;
        logic [BTN_W-1:0] btn;
    } t_key_hit;

    // Controller -> datapath
    typedef struct packed {
        logic load_item;
        logic poll_init;
        logic scan_chk;
        logic apply_evt;
        logic load_out;
        logic rd_en;
    } t_ctl_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic item_cmd;
        logic out_free;
    } t_ctl_sts;

    function automatic t_key_hit decode_key(input logic [15:0] code);
        t_key_hit r;
        r.hit = 1'b0;
        r.btn = '0;
        for (int i = 0; i < MAP_N; i++) begin
            if (KEY_CODES[i] == code) begin
                r.hit = 1'b1;
                r.btn = BTN_W'(i);
            end
        end
        return r;
    endfunction

endpackage

### design/ked_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ked_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ked_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 18,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/ked_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ked_ctrl: item sequencer
// Accepts a word, runs either the key event update or the deadline scan,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
module ked_ctrl #(
    parameter int BUTTON_COUNT = 18,
    localparam int IW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ked_pkg::t_ctl_sts i_sts,
    output ked_pkg::t_ctl_cmd o_cmd,
    output logic [IW-1:0]     o_idx,
    output logic [IW-1:0]     o_rd_addr
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_EVT,
        S_OUT
    } t_state;

    localparam logic [IW-1:0] LAST_IDX = IW'(BUTTON_COUNT - 1);

    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;

    always_comb begin
        o_cmd     = '0;
        o_rd_addr = '0;
        n_state   = r_state;
        n_idx     = r_idx;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = (i_sts.item_cmd == ked_pkg::CMD_POLL) ? S_INIT : S_EVT;
                end
            end
            S_INIT: begin
                o_cmd.poll_init = 1'b1;
                o_cmd.rd_en     = 1'b1;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                // check entry r_idx while fetching the next one
                o_cmd.scan_chk = 1'b1;
                o_cmd.rd_en    = (r_idx != LAST_IDX);
                o_rd_addr      = r_idx + IW'(1);
                if (r_idx == LAST_IDX) begin
                    n_state = S_OUT;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_EVT: begin
                o_cmd.apply_evt = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_idx      = r_idx;

endmodule

### design/ked_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ked_dp: keypad masks, deadline store and result register
// Holds the four button masks, the latched poll time, the config registers
// and the per-button repeat deadlines.
// ----------------------------------------------------------------------------
module ked_dp #(
    parameter int BUTTON_COUNT = 18,
    localparam int IW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ked_pkg::t_in_word                 i_in_word,
    input  ked_pkg::t_ctl_cmd                 i_cmd,
    input  logic [IW-1:0]                     i_idx,
    input  logic [IW-1:0]                     i_rd_addr,
    output ked_pkg::t_ctl_sts                 o_sts,
    input  logic                              i_cfg_we,
    input  logic [ked_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [15:0]                       i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output ked_pkg::t_out_word                o_out_word
);

    localparam int MW = (BUTTON_COUNT > ked_pkg::OUT_W) ? BUTTON_COUNT : ked_pkg::OUT_W;

    typedef logic [BUTTON_COUNT-1:0] t_mask;

    ked_pkg::t_in_word  r_item;
    ked_pkg::t_out_word r_out_word, n_out_word;
    logic               r_out_valid, n_out_valid;
    t_mask              r_held, n_held;
    t_mask              r_pressed, n_pressed;
    t_mask              r_released, n_released;
    t_mask              r_repeated, n_repeated;
    logic [31:0]        r_latched, n_latched;
    logic [15:0]        r_delay, n_delay;
    logic [15:0]        r_interval, n_interval;

    ked_pkg::t_key_hit  key;
    t_mask              key_bit;
    t_mask              idx_bit;
    logic               evt_ok;
    logic               is_release;
    logic               fresh_press;
    logic               due;
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic [31:0]        ram_rdata;

    ked_ram #(
        .WIDTH (32),
        .DEPTH (BUTTON_COUNT)
    ) u_deadline (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (ram_rdata)
    );

    // key event decode off the captured word
    always_comb begin
        key         = ked_pkg::decode_key(r_item.key_code);
        key_bit     = t_mask'(1) << key.btn;
        is_release  = (r_item.key_value == 32'sd0);
        evt_ok      = (r_item.event_type == ked_pkg::EVT_KEY)
                   && !(r_item.key_value > 32'sd1)
                   && key.hit
                   && ({1'b0, key.btn} < 6'(BUTTON_COUNT));
        fresh_press = !is_release && ((r_held & key_bit) == '0);
        idx_bit     = t_mask'(1) << i_idx;
        // unsigned compare against the latched poll time
        due         = r_held[i_idx] && (r_latched >= ram_rdata);
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = i_idx;
        ram_wdata = ram_rdata + 32'(r_interval);
        if (i_cmd.scan_chk) begin
            ram_we = due;
        end else if (i_cmd.apply_evt) begin
            ram_we    = evt_ok && fresh_press;
            ram_waddr = IW'(key.btn);
            ram_wdata = r_latched + 32'(r_delay);
        end
    end

    always_comb begin
        logic [MW-1:0] ext_held;
        logic [MW-1:0] ext_pressed;
        logic [MW-1:0] ext_released;
        logic [MW-1:0] ext_repeated;

        n_held      = r_held;
        n_pressed   = r_pressed;
        n_released  = r_released;
        n_repeated  = r_repeated;
        n_latched   = r_latched;
        n_delay     = r_delay;
        n_interval  = r_interval;
        n_out_word  = r_out_word;
        n_out_valid = r_out_valid & i_out_stall;

        ext_held     = MW'(r_held);
        ext_pressed  = MW'(r_pressed);
        ext_released = MW'(r_released);
        ext_repeated = MW'(r_repeated);

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                ked_pkg::CFG_DELAY_IDX:    n_delay    = i_cfg_data;
                ked_pkg::CFG_INTERVAL_IDX: n_interval = i_cfg_data;
                default: ;
            endcase
        end

        if (i_cmd.poll_init) begin
            n_latched  = r_item.now_ms;
            n_pressed  = '0;
            n_released = '0;
            n_repeated = '0;
        end

        if (i_cmd.scan_chk && due) begin
            n_repeated = r_repeated | idx_bit;
        end

        if (i_cmd.apply_evt && evt_ok) begin
            if (is_release) begin
                n_held     = r_held & ~key_bit;
                n_repeated = r_repeated & ~key_bit;
                n_released = r_released | key_bit;
            end else if (fresh_press) begin
                n_held     = r_held | key_bit;
                n_repeated = r_repeated | key_bit;
                n_pressed  = r_pressed | key_bit;
            end
        end

        if (i_cmd.load_out) begin
            n_out_valid                  = 1'b1;
            n_out_word.held_mask         = ext_held[ked_pkg::OUT_W-1:0];
            n_out_word.pressed_now_mask  = ext_pressed[ked_pkg::OUT_W-1:0];
            n_out_word.released_now_mask = ext_released[ked_pkg::OUT_W-1:0];
            n_out_word.repeated_now_mask = ext_repeated[ked_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_pressed   <= '0;
            r_released  <= '0;
            r_repeated  <= '0;
            r_latched   <= '0;
            r_delay     <= ked_pkg::DELAY_RST;
            r_interval  <= ked_pkg::INTERVAL_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_held      <= n_held;
            r_pressed   <= n_pressed;
            r_released  <= n_released;
            r_repeated  <= n_repeated;
            r_latched   <= n_latched;
            r_delay     <= n_delay;
            r_interval  <= n_interval;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_word;
        end
        r_out_word <= n_out_word;
    end

    assign o_sts.item_cmd = i_in_word.cmd;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_word     = r_out_word;

endmodule

### design/keypad_event_autorepeat_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_event_autorepeat_core: keypad state tracker with auto-repeat
// Tracks held buttons and per-poll pressed/released/repeated masks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word) carries one word per
//   item: a poll start (cmd 0, with the current ms time) or a raw key event
//   (cmd 1). Every accepted word yields exactly one result word on the
//   output channel (o_out_valid / i_out_stall / o_out_word) holding the four
//   masks as they stand after the item.
//   Sequence: a key event goes through the update state and then the output
//   load; a poll goes through the init state and the deadline scan, which
//   reads one deadline from the RAM read port per cycle, then the output
//   load. One word is in work at a time: the next one is taken the cycle
//   after the result is loaded into the output register, even while that
//   result is stalled.
//   A stalled output holds its word; a finished item waits for the output
//   register to free up before the next word is accepted.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 is the
//   repeat delay, index 1 the repeat interval. Write only while idle.
//   Reset (synchronous, active low) clears all masks and the latched time,
//   restores delay 300 / interval 100. Deadlines need no clearing: an entry
//   only counts for a held button, which always had it written first.
// ----------------------------------------------------------------------------
module keypad_event_autorepeat_core #(
    parameter int BUTTON_COUNT = 18
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ked_pkg::t_in_word             i_in_word,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ked_pkg::t_out_word            o_out_word,
    // config writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ked_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data
);

    localparam int IW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

    ked_pkg::t_ctl_cmd ctl_cmd;
    ked_pkg::t_ctl_sts ctl_sts;
    logic [IW-1:0]     scan_idx;
    logic [IW-1:0]     rd_addr;

    // registers are plain flops, so config is always taken
    assign o_cfg_ready = 1'b1;

    // sequencer: idle -> event update or init + scan -> output load
    ked_ctrl #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (ctl_sts),
        .o_cmd      (ctl_cmd),
        .o_idx      (scan_idx),
        .o_rd_addr  (rd_addr)
    );

    // masks, deadline RAM, config and output register
    ked_dp #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (ctl_cmd),
        .i_idx       (scan_idx),
        .i_rd_addr   (rd_addr),
        .o_sts       (ctl_sts),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

### design/ked_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ked_chk: port-level checks for the keypad auto-repeat core
// Watches the handshakes and result masks; bound onto the top level.
// ----------------------------------------------------------------------------
module ked_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ked_pkg::t_out_word o_out_word
);

    // no result pending right after reset
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result changed");

    // one word in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word taken while one is in work");

    // a button only repeats while it is held
    a_repeat_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out_word.repeated_now_mask & ~o_out_word.held_mask) == '0))
        else $error("repeat bit set on a button not held");

endmodule

bind keypad_event_autorepeat_core ked_chk u_ked_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

### tb/sv/keypad_event_autorepeat_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_event_autorepeat_core_test: self-checking bench for the keypad tracker
// Drives poll and key-event words with random gaps and output stalls, tracks
// held buttons and repeat deadlines in a local model, and compares every
// result word field by field in order. Covers the default, extreme and random
// delay/interval settings, time wrap, and a long output hold.
// ----------------------------------------------------------------------------
module keypad_event_autorepeat_core_test;
    import ked_pkg::*;

    localparam int BUTTONS        = 18;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 2 * BUTTONS + 6;

    // Raw code of each button, in button order
    localparam logic [15:0] BUTTON_CODE [BUTTONS] = '{
        16'd103, 16'd108, 16'd105, 16'd106, 16'd57, 16'd29, 16'd42, 16'd56,
        16'd28,  16'd97,  16'd1,   16'd18,  16'd15, 16'd20, 16'd14, 16'd115,
        16'd114, 16'd116
    };

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_word             i_in_word   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_word            o_out_word;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0]          i_cfg_data  = '0;

    keypad_event_autorepeat_core #(.BUTTON_COUNT(BUTTONS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Keypad model state
    logic [15:0]     mdl_delay    = 16'd300;
    logic [15:0]     mdl_interval = 16'd100;
    logic [BUTTONS-1:0] mdl_held     = '0;
    logic [BUTTONS-1:0] mdl_pressed  = '0;
    logic [BUTTONS-1:0] mdl_released = '0;
    logic [BUTTONS-1:0] mdl_repeated = '0;
    logic [31:0]     mdl_deadline [BUTTONS];
    logic [31:0]     mdl_time     = '0;

    t_out_word expected_masks [$];

    int mismatch_count = 0;
    int poll_count     = 0;
    int event_count    = 0;
    int setting_count  = 0;
    int repeat_results = 0;
    int idle_cycles    = 0;
    int hold_len       = 0;
    int stall_left     = 0;
    int dice           = 0;
    bit idling_on      = 1'b1;
    logic [31:0] session_ms = '0;

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------
    function automatic int button_of(input logic [15:0] code);
        for (int i = 0; i < BUTTONS; i++) begin
            if (BUTTON_CODE[i] == code) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_out_word track_keypad(input t_in_word w);
        t_out_word r;
        int        b;
        logic      above_one;
        if (w.cmd == CMD_POLL) begin
            mdl_time     = w.now_ms;
            mdl_pressed  = '0;
            mdl_released = '0;
            mdl_repeated = '0;
            for (int i = 0; i < BUTTONS; i++) begin
                if (mdl_held[i] && w.now_ms >= mdl_deadline[i]) begin
                    mdl_repeated[i] = 1'b1;
                    mdl_deadline[i] = mdl_deadline[i] + {16'd0, mdl_interval};
                end
            end
        end else begin
            b         = button_of(w.key_code);
            // OS-level key repeats (positive values above one) are dropped
            above_one = !w.key_value[31] && (w.key_value[30:0] > 31'd1);
            if (w.event_type == EVT_KEY && !above_one && b >= 0) begin
                if (w.key_value == 32'sd0) begin
                    mdl_held[b]     = 1'b0;
                    mdl_repeated[b] = 1'b0;
                    mdl_released[b] = 1'b1;
                end else if (!mdl_held[b]) begin
                    mdl_pressed[b]  = 1'b1;
                    mdl_repeated[b] = 1'b1;
                    mdl_held[b]     = 1'b1;
                    mdl_deadline[b] = mdl_time + {16'd0, mdl_delay};
                end
            end
        end
        r.held_mask         = mdl_held;
        r.pressed_now_mask  = mdl_pressed;
        r.released_now_mask = mdl_released;
        r.repeated_now_mask = mdl_repeated;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Word builders; unused fields carry junk to show they are ignored
    // ------------------------------------------------------------------------
    function automatic t_in_word poll_word(input logic [31:0] ms);
        t_in_word w;
        w.cmd        = CMD_POLL;
        w.now_ms     = ms;
        w.event_type = 16'($urandom());
        w.key_code   = 16'($urandom());
        w.key_value  = $urandom();
        return w;
    endfunction

    function automatic t_in_word key_word(input logic [15:0] etype,
                                          input logic [15:0] code,
                                          input logic [31:0] value);
        t_in_word w;
        w.cmd        = CMD_EVENT;
        w.now_ms     = $urandom();
        w.event_type = etype;
        w.key_code   = code;
        w.key_value  = value;
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idling_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Input side. Valid stays high after a word is taken so back-to-back words
    // need no low pulse; wait_quiet lowers it.
    // ------------------------------------------------------------------------
    task automatic issue_word(input t_in_word w);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_word  <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        expected_masks.push_back(track_keypad(w));
        if (w.cmd == CMD_POLL) begin
            poll_count++;
        end else begin
            event_count++;
        end
    endtask

    task automatic wait_quiet();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_masks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_DELAY_IDX) begin
            mdl_delay = value;
        end else begin
            mdl_interval = value;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_timing(input logic [15:0] delay, input logic [15:0] interval);
        write_register(CFG_DELAY_IDX, delay);
        write_register(CFG_INTERVAL_IDX, interval);
        setting_count++;
    endtask

    // Mostly clean press/release traffic with advancing time, plus noise
    task automatic run_session(input int n_items);
        int          r;
        int          b;
        int          step_max;
        logic [31:0] v;
        step_max = (int'(mdl_delay) + int'(mdl_interval)) / 3 + 20;
        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                if ($urandom_range(0, 49) == 0) begin
                    session_ms = $urandom();
                end else begin
                    session_ms = session_ms + $urandom_range(0, step_max);
                end
                issue_word(poll_word(session_ms));
            end else if (r < 85) begin
                b = $urandom_range(0, BUTTONS - 1);
                dice = $urandom_range(0, 9);
                if (mdl_held[b]) begin
                    v = (dice < 7) ? 32'd0 : 32'd1;
                end else if (dice < 8) begin
                    v = 32'd1;
                end else if (dice < 9) begin
                    v = {1'b1, 31'($urandom())};
                end else begin
                    v = 32'd0;
                end
                issue_word(key_word(EVT_KEY, BUTTON_CODE[b], v));
            end else if (r < 93) begin
                // near misses: repeat values or wrong event types on real keys
                b = $urandom_range(0, BUTTONS - 1);
                if ($urandom_range(0, 1) == 0) begin
                    v = $urandom_range(2, 32'h7FFF_FFFF);
                    issue_word(key_word(EVT_KEY, BUTTON_CODE[b], v));
                end else begin
                    v = $urandom_range(0, 1);
                    issue_word(key_word(16'($urandom_range(2, 65535)) ^ 16'h0,
                                        BUTTON_CODE[b], v));
                end
            end else begin
                issue_word(key_word(16'($urandom()), 16'($urandom()), $urandom()));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stalls, plus a counted long hold on request
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_len > 0) begin
            hold_len = hold_len - 1;
            i_out_stall <= 1'b1;
        end else if (!idling_on) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            dice = $urandom_range(0, 99);
            if (dice < 75) begin
                i_out_stall <= 1'b0;
            end else if (dice < 96) begin
                stall_left = $urandom_range(0, 2);
                i_out_stall <= 1'b1;
            end else begin
                stall_left = $urandom_range(10, 40);
                i_out_stall <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
        if (want !== got) begin
            if (mismatch_count < 10) begin
                $display("%0t: %s expected %05h got %05h", $realtime, name, want, got);
            end
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_masks.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("%0t: result word with nothing pending: %h",
                             $realtime, o_out_word);
                end
                mismatch_count++;
            end else begin
                want = expected_masks.pop_front();
                check_field("held_mask", want.held_mask, o_out_word.held_mask);
                check_field("pressed_now_mask", want.pressed_now_mask,
                            o_out_word.pressed_now_mask);
                check_field("released_now_mask", want.released_now_mask,
                            o_out_word.released_now_mask);
                check_field("repeated_now_mask", want.repeated_now_mask,
                            o_out_word.repeated_now_mask);
                if (want.repeated_now_mask != '0) begin
                    repeat_results++;
                end
            end
        end
    end

    // Ends the run if no channel moves a word for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset timing (delay 300, interval 100): press forms, ignored events,
    // unsigned deadline compare and wrap of the time base
    task automatic test_directed_defaults();
        issue_word(poll_word(32'd0));
        issue_word(key_word(EVT_KEY, 16'd103, 32'd1));           // up
        issue_word(key_word(EVT_KEY, 16'd57, 32'h8000_0000));    // A, negative press
        issue_word(key_word(EVT_KEY, 16'd116, 32'd1));           // power
        issue_word(key_word(EVT_KEY, 16'd103, 32'd1));           // already held
        issue_word(key_word(EVT_KEY, 16'd103, 32'd2));           // repeat value
        issue_word(key_word(EVT_KEY, 16'd103, 32'h7FFF_FFFF));
        issue_word(key_word(16'd0, 16'd103, 32'd0));             // wrong type
        issue_word(key_word(16'hFFFF, 16'd103, 32'd0));
        issue_word(key_word(EVT_KEY, 16'd0, 32'd1));             // unknown codes
        issue_word(key_word(EVT_KEY, 16'hFFFF, 32'd0));
        issue_word(key_word(EVT_KEY, 16'd108, 32'd0));           // release, not held
        issue_word(poll_word(32'd299));
        issue_word(poll_word(32'd300));
        issue_word(key_word(EVT_KEY, 16'd57, 32'd0));
        issue_word(poll_word(32'd400));
        issue_word(poll_word(32'hFFFF_FFF0));
        issue_word(key_word(EVT_KEY, 16'd114, 32'hFFFF_FFFF));   // deadline wraps
        issue_word(poll_word(32'hFFFF_FFFF));
        issue_word(poll_word(32'd0));
        issue_word(key_word(EVT_KEY, 16'd116, 32'd0));
        issue_word(key_word(EVT_KEY, 16'd103, 32'd0));
        issue_word(key_word(EVT_KEY, 16'd114, 32'd0));
        issue_word(poll_word(32'd5));
        wait_quiet();
    endtask

    // Register extremes, zero interval and zero delay among them
    task automatic test_register_extremes();
        set_timing(16'd0, 16'd0);
        session_ms = $urandom_range(0, 1000);
        run_session(90);
        wait_quiet();
        set_timing(16'hFFFF, 16'hFFFF);
        session_ms = 32'hFFFF_FFFF - $urandom_range(0, 200000);
        run_session(90);
        wait_quiet();
        set_timing(16'd0, 16'hFFFF);
        run_session(90);
        wait_quiet();
        set_timing(16'hFFFF, 16'd1);
        run_session(90);
        wait_quiet();
    endtask

    // Random timing per session; one session runs with no gaps or stalls
    task automatic test_random_sessions();
        logic [15:0] delay;
        logic [15:0] interval;
        for (int s = 0; s < 7; s++) begin
            delay    = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                   : 16'($urandom_range(0, 600));
            interval = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                   : 16'($urandom_range(1, 300));
            set_timing(delay, interval);
            if (s % 3 == 2) begin
                session_ms = 32'hFFFF_FFFF - $urandom_range(0, 5000);
            end else begin
                session_ms = $urandom();
            end
            idling_on = (s != 3);
            run_session(130);
            wait_quiet();
        end
        idling_on = 1'b1;
    endtask

    // Receiver holds off long enough that the block backs up into its input
    task automatic test_output_backpressure();
        idling_on = 1'b0;
        hold_len  = 400;
        run_session(40);
        wait_quiet();
        idling_on = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_defaults();
        test_register_extremes();
        test_random_sessions();
        test_output_backpressure();
        mismatch_count += expected_masks.size();
        $display("Run covered %0d polls and %0d key events under %0d timing settings;",
                 poll_count, event_count, setting_count + 1);
        $display("%0d result words reported auto-repeats.", repeat_results);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
